[hdl/pwc_pkg.sv]
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared types and constants of the square-wave sound channel.
// ----------------------------------------------------------------------------
package pwc_pkg;

   // Widths of the channel's fields and state
   localparam int unsigned PERIOD_W  = 11;
   localparam int unsigned LENGTH_W  = 8;
   localparam int unsigned LEVEL_W   = 4;
   localparam int unsigned STEP_W    = 3;
   localparam int unsigned ACTION_W  = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 4;

   // Sweep mutes below this period and above the period limit
   localparam logic [PERIOD_W-1:0] MIN_PERIOD   = 11'd8;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 4'd15;

   // Default channel: the first one (ones' complement negate)
   localparam bit DEF_SECOND_CHANNEL = 1'b0;

   // Duty patterns, bit i is step i of the sequence
   localparam logic [7:0] DUTY_TABLE [4] = '{
      8'b1000_0000,
      8'b1100_0000,
      8'b1111_0000,
      8'b0011_1111
   };

   // Event codes on the request channel
   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK       = 3'd0,
      ACT_QUARTER    = 3'd1,
      ACT_HALF       = 3'd2,
      ACT_LOAD_LEN   = 3'd3,
      ACT_SWEEP_LOAD = 3'd4,
      ACT_DEACTIVATE = 3'd5,
      ACT_PERIOD     = 3'd6
   } action_type;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DUTY_SELECT   = 3'd0,
      CSR_LENGTH_HALT   = 3'd1,
      CSR_CONST_VOLUME  = 3'd2,
      CSR_VOLUME_LEVEL  = 3'd3,
      CSR_SWEEP_ENABLE  = 3'd4,
      CSR_SWEEP_PERIOD  = 3'd5,
      CSR_SWEEP_NEGATE  = 3'd6,
      CSR_SWEEP_SHIFT   = 3'd7
   } csr_index_type;

   // Configuration bundle handed from the top level to the core
   typedef struct packed {
      logic [1:0]         duty_select;
      logic               length_halt_loop;
      logic               constant_volume;
      logic [LEVEL_W-1:0] volume_level;
      logic               sweep_enable;
      logic [2:0]         sweep_divider_period;
      logic               sweep_negate;
      logic [2:0]         sweep_shift;
   } cfg_type;

endpackage

[hdl/pwc_sweep.sv]
// ----------------------------------------------------------------------------
// pwc_sweep
// Sweep target period and muting check for one timer period.
// ----------------------------------------------------------------------------
module pwc_sweep
   import pwc_pkg::*;
#(
   parameter bit IS_SECOND_CHANNEL = DEF_SECOND_CHANNEL
) (
   input  logic [PERIOD_W-1:0] period,
   input  logic                sweep_negate,
   input  logic [2:0]          sweep_shift,
   output logic [PERIOD_W-1:0] target,
   output logic                mute
);

   logic [PERIOD_W-1:0] change;
   logic [PERIOD_W:0]   sum;
   logic [PERIOD_W:0]   diff;
   logic [PERIOD_W:0]   target_wide;
   logic                borrow;

   // First channel negates in ones' complement: one extra subtracted
   assign borrow = IS_SECOND_CHANNEL ? 1'b0 : 1'b1;
   assign change = period >> sweep_shift;
   assign sum    = {1'b0, period} + {1'b0, change};
   assign diff   = {1'b0, period} - {1'b0, change} - {{PERIOD_W{1'b0}}, borrow};

   // Top bit set means above the limit, or wrapped below zero
   assign target_wide = sweep_negate ? diff : sum;
   assign target      = target_wide[PERIOD_W-1:0];
   assign mute        = (period < MIN_PERIOD) || target_wide[PERIOD_W];

endmodule

[hdl/pwc_core.sv]
// ----------------------------------------------------------------------------
// pwc_core
// Channel state: timer, duty step, length, sweep and envelope, updated by one
// event per cycle while fire is high, with the sample taken from the updated state.
// ----------------------------------------------------------------------------
module pwc_core
   import pwc_pkg::*;
#(
   parameter bit IS_SECOND_CHANNEL = DEF_SECOND_CHANNEL
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  action_type          action,
   input  logic [PERIOD_W-1:0] value,
   input  cfg_type             cfg,
   output logic [LEVEL_W-1:0]  sample,
   output logic                is_active
);

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] countdown_ff, countdown_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [2:0]          sweep_count_ff, sweep_count_in;
   logic                sweep_reload_ff, sweep_reload_in;
   logic                env_start_ff, env_start_in;
   logic [LEVEL_W-1:0]  env_divider_ff, env_divider_in;
   logic [LEVEL_W-1:0]  env_decay_ff, env_decay_in;

   logic [PERIOD_W-1:0] target_cur;
   logic                mute_cur;
   logic [PERIOD_W-1:0] target_next;
   logic                mute_next;
   logic [7:0]          duty_row;
   logic [LEVEL_W-1:0]  level;

   // Sweep check on the period before the event (for write-back)
   pwc_sweep #(
      .IS_SECOND_CHANNEL (IS_SECOND_CHANNEL)
   ) u_sweep_cur (
      .period       (period_ff),
      .sweep_negate (cfg.sweep_negate),
      .sweep_shift  (cfg.sweep_shift),
      .target       (target_cur),
      .mute         (mute_cur)
   );

   // Sweep check on the period after the event (for the sample)
   pwc_sweep #(
      .IS_SECOND_CHANNEL (IS_SECOND_CHANNEL)
   ) u_sweep_next (
      .period       (period_in),
      .sweep_negate (cfg.sweep_negate),
      .sweep_shift  (cfg.sweep_shift),
      .target       (target_next),
      .mute         (mute_next)
   );

   // Next state for the current event
   always_comb begin
      period_in       = period_ff;
      countdown_in    = countdown_ff;
      step_in         = step_ff;
      length_in       = length_ff;
      sweep_count_in  = sweep_count_ff;
      sweep_reload_in = sweep_reload_ff;
      env_start_in    = env_start_ff;
      env_divider_in  = env_divider_ff;
      env_decay_in    = env_decay_ff;

      unique case (action)
         ACT_TICK: begin
            if (countdown_ff == '0) begin
               countdown_in = period_ff;
               step_in      = step_ff - 1'b1;
            end else begin
               countdown_in = countdown_ff - 1'b1;
            end
         end
         ACT_QUARTER: begin
            if (env_start_ff) begin
               env_start_in   = 1'b0;
               env_decay_in   = LEVEL_MAX;
               env_divider_in = cfg.volume_level;
            end else if (env_divider_ff == '0) begin
               env_divider_in = cfg.volume_level;
               if (env_decay_ff != '0) begin
                  env_decay_in = env_decay_ff - 1'b1;
               end else if (cfg.length_halt_loop) begin
                  env_decay_in = LEVEL_MAX;
               end
            end else begin
               env_divider_in = env_divider_ff - 1'b1;
            end
         end
         ACT_HALF: begin
            if (length_ff != '0 && !cfg.length_halt_loop) begin
               length_in = length_ff - 1'b1;
            end
            if (cfg.sweep_enable && cfg.sweep_shift != '0 &&
                sweep_count_ff == '0 && !mute_cur) begin
               period_in = target_cur;
            end
            if (sweep_count_ff == '0 || sweep_reload_ff) begin
               sweep_reload_in = 1'b0;
               sweep_count_in  = cfg.sweep_divider_period;
            end else begin
               sweep_count_in = sweep_count_ff - 1'b1;
            end
         end
         ACT_LOAD_LEN: begin
            length_in    = value[LENGTH_W-1:0];
            step_in      = '0;
            env_start_in = 1'b1;
         end
         ACT_SWEEP_LOAD: begin
            sweep_reload_in = 1'b1;
         end
         ACT_DEACTIVATE: begin
            length_in = '0;
         end
         ACT_PERIOD: begin
            period_in = value;
         end
         default: begin
            // unused code: state holds
         end
      endcase
   end

   // Sample from the updated state
   assign duty_row  = DUTY_TABLE[cfg.duty_select];
   assign level     = cfg.constant_volume ? cfg.volume_level : env_decay_in;
   assign is_active = (length_in != '0);
   assign sample    = (is_active && !mute_next && duty_row[step_in]) ? level : '0;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= '0;
         countdown_ff    <= '0;
         step_ff         <= '0;
         length_ff       <= '0;
         sweep_count_ff  <= '0;
         sweep_reload_ff <= 1'b0;
         env_start_ff    <= 1'b0;
         env_divider_ff  <= '0;
         env_decay_ff    <= '0;
      end else if (fire) begin
         period_ff       <= period_in;
         countdown_ff    <= countdown_in;
         step_ff         <= step_in;
         length_ff       <= length_in;
         sweep_count_ff  <= sweep_count_in;
         sweep_reload_ff <= sweep_reload_in;
         env_start_ff    <= env_start_in;
         env_divider_ff  <= env_divider_in;
         env_decay_ff    <= env_decay_in;
      end
   end

endmodule

[hdl/pulse_wave_channel.sv]
// ----------------------------------------------------------------------------
// pulse_wave_channel
// Square-wave sound channel: one event per beat in, one sample per beat out.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+-----------
//  req     | req_valid/req_stall, action, value     | event in
//  rsp     | rsp_valid/rsp_stall, sample, is_active | result out
//  csr     | csr_wr_en, csr_index, csr_data         | register write
//
//  One event per cycle sustained while rsp is not stalled; each event passes
//  through the input register, then the state update and result register.
//  The event is applied and the sample formed in the cycle it leaves the
//  input register, so the state update path sets the cycle time.
//  Reset clears the valid flags, the configuration and all channel state.
//  A stall on rsp holds the result; the input register then fills and
//  req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module pulse_wave_channel
   import pwc_pkg::*;
#(
   parameter bit IS_SECOND_CHANNEL = DEF_SECOND_CHANNEL
) (
   input  logic                  clock,
   input  logic                  reset,
   // event channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [PERIOD_W-1:0]   req_value,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LEVEL_W-1:0]    rsp_sample,
   output logic                  rsp_is_active,
   // register writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic                in_valid_ff, in_valid_in;
   logic [ACTION_W-1:0] action_ff;
   logic [PERIOD_W-1:0] value_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]  sample_ff;
   logic                active_ff;

   logic                accept;
   logic                advance;
   logic                fire;
   logic [LEVEL_W-1:0]  core_sample;
   logic                core_active;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DUTY_SELECT:  cfg_in.duty_select          = csr_data[1:0];
            CSR_LENGTH_HALT:  cfg_in.length_halt_loop     = csr_data[0];
            CSR_CONST_VOLUME: cfg_in.constant_volume      = csr_data[0];
            CSR_VOLUME_LEVEL: cfg_in.volume_level         = csr_data;
            CSR_SWEEP_ENABLE: cfg_in.sweep_enable         = csr_data[0];
            CSR_SWEEP_PERIOD: cfg_in.sweep_divider_period = csr_data[2:0];
            CSR_SWEEP_NEGATE: cfg_in.sweep_negate         = csr_data[0];
            CSR_SWEEP_SHIFT:  cfg_in.sweep_shift          = csr_data[2:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake: the result register frees up when empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? fire : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         value_ff  <= req_value;
      end
   end

   pwc_core #(
      .IS_SECOND_CHANNEL (IS_SECOND_CHANNEL)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .action    (action_type'(action_ff)),
      .value     (value_ff),
      .cfg       (cfg_ff),
      .sample    (core_sample),
      .is_active (core_active)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (fire) begin
         sample_ff <= core_sample;
         active_ff <= core_active;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sample    = sample_ff;
   assign rsp_is_active = active_ff;

   // A silent channel never sounds
   a_mute_when_inactive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_active) |-> (rsp_sample == '0))
      else $error("sample nonzero while length counter is zero");

   // Back-pressure only while an event waits in the input register
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall raised with empty input register");

   // An accepted beat is held until it moves to the result register
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted beat lost from input register");

   // Every processed event produces a result beat
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed event did not produce a result");

endmodule

[verif/tb_pulse_wave_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_wave_channel
// Self-checking bench for the square-wave channel. A behavioural copy of the
// channel state predicts the sample and active flag of every event beat. The
// result beats are compared in order against the predictions. Directed
// events and sweep corner cases run first, then a back-pressure test, then
// random event streams under several register settings. Both handshake sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_pulse_wave_channel;
   import pwc_pkg::*;

   localparam bit                  SECOND_CHANNEL = DEF_SECOND_CHANNEL;
   localparam logic [ACTION_W-1:0] ACT_UNUSED     = 3'd7;
   localparam logic [15:0]         PERIOD_LIMIT   = 16'h07FF;
   localparam int                  HOLD_CYCLES    = 60;
   localparam int                  WATCHDOG_LIMIT = 2000;
   localparam int                  RANDOM_PHASES  = 6;
   localparam int                  BURST_BEATS    = 180;
   localparam int                  MAX_PRINTS     = 30;

   // duty patterns, bit n set when step n is high
   localparam logic [7:0] DUTY_PATTERN [4] = '{8'h80, 8'hC0, 8'hF0, 8'h3F};

   typedef struct packed {
      logic [LEVEL_W-1:0] sample;
      logic               is_active;
   } sample_beat_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ACTION_W-1:0]   req_action;
   logic [PERIOD_W-1:0]   req_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [LEVEL_W-1:0]    rsp_sample;
   logic                  rsp_is_active;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predicted register file
   logic [1:0]          cfg_duty;
   logic                cfg_halt;
   logic                cfg_const;
   logic [LEVEL_W-1:0]  cfg_volume;
   logic                cfg_sw_en;
   logic [2:0]          cfg_sw_period;
   logic                cfg_sw_negate;
   logic [2:0]          cfg_sw_shift;

   // predicted channel state
   logic [PERIOD_W-1:0] ch_period;
   logic [PERIOD_W-1:0] ch_countdown;
   logic [STEP_W-1:0]   ch_step;
   logic [LENGTH_W-1:0] ch_length;
   logic [2:0]          ch_sweep_cnt;
   logic                ch_sweep_reload;
   logic                ch_env_start;
   logic [LEVEL_W-1:0]  ch_env_div;
   logic [LEVEL_W-1:0]  ch_env_decay;

   sample_beat_type sample_queue [$];
   sample_beat_type expected_beat;

   int error_count  = 0;
   int event_count  = 0;
   int result_count = 0;
   int reg_writes   = 0;
   int stall_left   = 0;
   int idle_cycles  = 0;
   bit quiet        = 1'b0;
   bit long_hold    = 1'b0;

   pulse_wave_channel #(.IS_SECOND_CHANNEL(SECOND_CHANNEL)) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .rsp_is_active (rsp_is_active),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Channel prediction
   // ------------------------------------------------------------------------
   task automatic reset_channel_model();
      cfg_duty        = '0;
      cfg_halt        = 1'b0;
      cfg_const       = 1'b0;
      cfg_volume      = '0;
      cfg_sw_en       = 1'b0;
      cfg_sw_period   = '0;
      cfg_sw_negate   = 1'b0;
      cfg_sw_shift    = '0;
      ch_period       = '0;
      ch_countdown    = '0;
      ch_step         = '0;
      ch_length       = '0;
      ch_sweep_cnt    = '0;
      ch_sweep_reload = 1'b0;
      ch_env_start    = 1'b0;
      ch_env_div      = '0;
      ch_env_decay    = '0;
   endtask

   // sweep target, 16-bit wrap; first channel negates in ones' complement
   function automatic logic [15:0] sweep_target_period();
      logic [15:0] delta;
      logic [15:0] target;
      delta = 16'(ch_period >> cfg_sw_shift);
      if (cfg_sw_negate) begin
         target = {5'd0, ch_period} - delta;
         if (!SECOND_CHANNEL) target = target - 16'd1;
      end else begin
         target = {5'd0, ch_period} + delta;
      end
      return target;
   endfunction

   function automatic bit sweep_mutes();
      return (ch_period < MIN_PERIOD) || (sweep_target_period() > PERIOD_LIMIT);
   endfunction

   // apply one event to the predicted state and form the result beat
   task automatic advance_channel(input logic [ACTION_W-1:0] action,
                                  input logic [PERIOD_W-1:0] value,
                                  output sample_beat_type beat);
      logic [15:0]        target;
      logic               audible;
      logic [LEVEL_W-1:0] level;
      case (action)
         ACT_TICK: begin
            if (ch_countdown == '0) begin
               ch_countdown = ch_period;
               ch_step      = ch_step - 3'd1;
            end else begin
               ch_countdown = ch_countdown - 11'd1;
            end
         end
         ACT_QUARTER: begin
            if (ch_env_start) begin
               ch_env_start = 1'b0;
               ch_env_decay = LEVEL_MAX;
               ch_env_div   = cfg_volume;
            end else if (ch_env_div == '0) begin
               ch_env_div = cfg_volume;
               if (ch_env_decay != '0) ch_env_decay = ch_env_decay - 4'd1;
               else if (cfg_halt) ch_env_decay = LEVEL_MAX;
            end else begin
               ch_env_div = ch_env_div - 4'd1;
            end
         end
         ACT_HALF: begin
            if (ch_length != '0 && !cfg_halt) ch_length = ch_length - 8'd1;
            target = sweep_target_period();
            if (cfg_sw_en && cfg_sw_shift != '0 && ch_sweep_cnt == '0 && !sweep_mutes())
               ch_period = target[PERIOD_W-1:0];
            if (ch_sweep_cnt == '0 || ch_sweep_reload) begin
               ch_sweep_reload = 1'b0;
               ch_sweep_cnt    = cfg_sw_period;
            end else begin
               ch_sweep_cnt = ch_sweep_cnt - 3'd1;
            end
         end
         ACT_LOAD_LEN: begin
            ch_length    = value[LENGTH_W-1:0];
            ch_step      = '0;
            ch_env_start = 1'b1;
         end
         ACT_SWEEP_LOAD: ch_sweep_reload = 1'b1;
         ACT_DEACTIVATE: ch_length = '0;
         ACT_PERIOD:     ch_period = value;
         default: ;
      endcase
      audible = (ch_length != '0) && !sweep_mutes() && DUTY_PATTERN[cfg_duty][ch_step];
      level   = cfg_const ? cfg_volume : ch_env_decay;
      beat.sample    = audible ? level : '0;
      beat.is_active = (ch_length != '0);
   endtask

   // ------------------------------------------------------------------------
   // Sending side
   // ------------------------------------------------------------------------
   // entered and left just after a falling edge
   task automatic send_event(input logic [ACTION_W-1:0] action,
                             input logic [PERIOD_W-1:0] value);
      int              gap;
      sample_beat_type beat;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action = action;
      req_value  = value;
      req_valid  = 1'b1;
      do @(posedge clock); while (req_stall);
      advance_channel(action, value, beat);
      sample_queue.push_back(beat);
      event_count++;
      @(negedge clock);
   endtask

   function automatic logic [PERIOD_W-1:0] any_value();
      return 11'($urandom_range(0, 2047));
   endfunction

   // wait until every predicted beat has come back, then let the pipe settle
   task automatic drain_results();
      req_valid = 1'b0;
      while (sample_queue.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [3:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_DUTY_SELECT:  cfg_duty      = data[1:0];
         CSR_LENGTH_HALT:  cfg_halt      = data[0];
         CSR_CONST_VOLUME: cfg_const     = data[0];
         CSR_VOLUME_LEVEL: cfg_volume    = data;
         CSR_SWEEP_ENABLE: cfg_sw_en     = data[0];
         CSR_SWEEP_PERIOD: cfg_sw_period = data[2:0];
         CSR_SWEEP_NEGATE: cfg_sw_negate = data[0];
         CSR_SWEEP_SHIFT:  cfg_sw_shift  = data[2:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // registers change only once the channel has gone idle
   task automatic apply_settings(input logic [1:0] duty, input logic halt,
                                 input logic cv, input logic [3:0] vol,
                                 input logic sw_en, input logic [2:0] sw_period,
                                 input logic sw_neg, input logic [2:0] sw_shift);
      drain_results();
      write_register(CSR_DUTY_SELECT,  {2'b00, duty});
      write_register(CSR_LENGTH_HALT,  {3'b000, halt});
      write_register(CSR_CONST_VOLUME, {3'b000, cv});
      write_register(CSR_VOLUME_LEVEL, vol);
      write_register(CSR_SWEEP_ENABLE, {3'b000, sw_en});
      write_register(CSR_SWEEP_PERIOD, {1'b0, sw_period});
      write_register(CSR_SWEEP_NEGATE, {3'b000, sw_neg});
      write_register(CSR_SWEEP_SHIFT,  {1'b0, sw_shift});
   endtask

   // weighted event mix; some picks are a whole note start
   task automatic send_random_event();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 42)      send_event(ACT_TICK, any_value());
      else if (pick < 52) send_event(ACT_QUARTER, any_value());
      else if (pick < 62) send_event(ACT_HALF, any_value());
      else if (pick < 68) send_event(ACT_LOAD_LEN, any_value());
      else if (pick < 75) begin
         if ($urandom_range(0, 3) != 0) send_event(ACT_PERIOD, 11'($urandom_range(8, 64)));
         else send_event(ACT_PERIOD, any_value());
      end
      else if (pick < 81) send_event(ACT_SWEEP_LOAD, any_value());
      else if (pick < 84) send_event(ACT_DEACTIVATE, any_value());
      else if (pick < 86) send_event(ACT_UNUSED, any_value());
      else begin
         // note start: nonzero length, audible period, envelope restart
         send_event(ACT_LOAD_LEN,
                    11'($urandom_range(0, 7) * 256 + $urandom_range(1, 255)));
         send_event(ACT_PERIOD, 11'($urandom_range(8, 40)));
         send_event(ACT_QUARTER, any_value());
      end
   endtask

   task automatic run_random_burst(input int beats);
      for (int n = 0; n < beats; n++) begin
         // now and then a stretch with no idling on either side
         if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         send_random_event();
      end
      quiet = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_event_codes();
      apply_settings(2'd3, 1'b0, 1'b1, 4'd15, 1'b0, 3'd0, 1'b0, 3'd0);
      send_event(ACT_PERIOD, 11'h7FF);    // largest period, target overflows
      send_event(ACT_LOAD_LEN, 11'h7FF);  // length takes the low byte only
      send_event(ACT_PERIOD, 11'd8);      // lowest audible period
      send_event(ACT_PERIOD, 11'd7);      // below the floor, muted
      send_event(ACT_PERIOD, 11'd0);
      send_event(ACT_TICK, 11'h7FF);      // countdown empty, step wraps
      send_event(ACT_PERIOD, 11'd9);
      send_event(ACT_TICK, 11'd0);        // reload from period
      send_event(ACT_PERIOD, 11'd12);     // countdown left alone
      send_event(ACT_TICK, 11'd0);
      send_event(ACT_QUARTER, 11'd0);
      send_event(ACT_HALF, 11'd0);
      send_event(ACT_UNUSED, 11'h7FF);    // unused code, nothing changes
      send_event(ACT_DEACTIVATE, 11'd0);
      send_event(ACT_LOAD_LEN, 11'd256);  // low byte zero
      send_event(ACT_LOAD_LEN, 11'd1);
      send_event(ACT_HALF, 11'd0);        // length runs out
   endtask

   task automatic test_sweep_edges();
      // envelope output, sweep adding half the period each half frame
      apply_settings(2'd2, 1'b1, 1'b0, 4'd0, 1'b1, 3'd0, 1'b0, 3'd1);
      send_event(ACT_LOAD_LEN, 11'd200);
      send_event(ACT_QUARTER, 11'd0);
      send_event(ACT_PERIOD, 11'd100);
      send_event(ACT_HALF, 11'd0);        // period written back
      send_event(ACT_SWEEP_LOAD, 11'd0);
      send_event(ACT_HALF, 11'd0);
      // negating sweep from period zero wraps below zero
      apply_settings(2'd2, 1'b1, 1'b0, 4'd0, 1'b1, 3'd0, 1'b1, 3'd1);
      send_event(ACT_PERIOD, 11'd0);
      send_event(ACT_HALF, 11'd0);
   endtask

   task automatic test_back_pressure();
      // receiver holds off while events keep coming, so the input stalls
      quiet     = 1'b1;
      long_hold = 1'b1;
      repeat (24) send_random_event();
      quiet = 1'b0;
      // sender pauses until every beat has come back
      drain_results();
      repeat (16) send_random_event();
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_settings(2'd0, 1'b0, 1'b0, 4'd0, 1'b0, 3'd0, 1'b0, 3'd0);
            1: apply_settings(2'd3, 1'b1, 1'b1, 4'd15, 1'b1, 3'd7, 1'b1, 3'd7);
            default: begin
               apply_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            end
         endcase
         run_random_burst(BURST_BEATS);
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiving side and checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("mismatch on result beat %0d at %0t: %s", result_count, $realtime, msg);
   endtask

   // stall drawn per beat, or one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // compare each accepted result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (sample_queue.size() == 0) begin
            report_mismatch("result beat with no event outstanding");
         end else begin
            expected_beat = sample_queue.pop_front();
            if (rsp_sample !== expected_beat.sample)
               report_mismatch($sformatf("sample %0d, predicted %0d",
                                         rsp_sample, expected_beat.sample));
            if (rsp_is_active !== expected_beat.is_active)
               report_mismatch($sformatf("is_active %0b, predicted %0b",
                                         rsp_is_active, expected_beat.is_active));
         end
         stall_left = quiet ? 0 : $urandom_range(0, 3);
      end
   end

   // watchdog on cycles with no beat accepted on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, sample_queue.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = ACT_TICK;
      req_value  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_DUTY_SELECT;
      csr_data   = '0;
      reset_channel_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_event_codes();
      test_sweep_edges();
      test_back_pressure();
      test_random_settings();

      drain_results();
      repeat (8) @(posedge clock);
      $display("run covered %0d events and %0d result beats, %0d register writes",
               event_count, result_count, reg_writes);
      $display("directed codes, sweep corners, back-pressure and %0d random settings",
               RANDOM_PHASES);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/pwc_pkg.sv
hdl/pwc_sweep.sv
hdl/pwc_core.sv
hdl/pulse_wave_channel.sv
verif/tb_pulse_wave_channel.sv
